[rtl/core/cwsi_pkg.sv]
// ----------------------------------------------------------------------------
// cwsi_pkg
// Shared types, constants and tables of the CT window and slice
// interpolation block.
// ----------------------------------------------------------------------------
`default_nettype none

package cwsi_pkg;

    // Store and counter sizes
    localparam int MAX_SLICE_PIXELS = 262144;
    localparam int MAX_SLICES       = 1024;
    localparam int MAX_THICKNESS    = 16;
    localparam int PIX_W            = $clog2(MAX_SLICE_PIXELS);
    localparam int SLC_W            = $clog2(MAX_SLICES);

    // Field widths
    localparam int HU_W     = 16;
    localparam int VOX_W    = 8;
    localparam int OSLICE_W = 14;
    localparam int THICK_W  = 5;
    localparam int NPIX_W   = 19;
    localparam int CFG_W    = 19;
    localparam int LCNT_W   = 4;
    localparam int ACC_W    = 12;
    localparam int RECIP_W  = 17;
    localparam int FILL_SHIFT = 16;

    // Window [-128, 1023] to a byte: (v + 128) * 255 / 1151
    localparam logic signed [HU_W-1:0] WIN_LOW  = -16'sd128;
    localparam logic signed [HU_W-1:0] WIN_HIGH = 16'sd1023;
    localparam logic [HU_W:0]          WIN_OFFSET = 17'd128;
    localparam logic [VOX_W-1:0]       BYTE_MAX = 8'd255;
    // ceil(2^30 / 1151), exact for every numerator below 2^19
    localparam logic [19:0]            WIN_RECIP = 20'd932878;
    localparam int                     WIN_SHIFT = 30;

    localparam logic [THICK_W-1:0] THICK_MAX = 5'd16;
    localparam logic [NPIX_W-1:0]  NPIX_MAX  = 19'd262144;

    // Configuration register indexes
    localparam logic REG_SLICE_THICKNESS = 1'b0;
    localparam logic REG_SLICE_PIXELS    = 1'b1;

    // Input and output words
    typedef struct packed {
        logic signed [HU_W-1:0] hu_sample;
        logic                   first_of_volume;
    } sample_t;

    typedef struct packed {
        logic [VOX_W-1:0]    voxel_value;
        logic [OSLICE_W-1:0] out_slice;
        logic [PIX_W-1:0]    out_pixel;
        logic                last_of_run;
    } voxel_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic win_mul;
        logic win_res;
        logic fill_step;
        logic load_fill;
        logic load_real;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fill_en;
        logic last_fill;
        logic out_free;
    } status_t;

    // ceil(2^16 / t): exact quotient for numerators below 2^12, t up to 16
    function automatic logic [RECIP_W-1:0] fill_recip(input logic [THICK_W-1:0] t);
        logic [RECIP_W-1:0] r;
        case (t)
            5'd2:    r = 17'd32768;
            5'd3:    r = 17'd21846;
            5'd4:    r = 17'd16384;
            5'd5:    r = 17'd13108;
            5'd6:    r = 17'd10923;
            5'd7:    r = 17'd9363;
            5'd8:    r = 17'd8192;
            5'd9:    r = 17'd7282;
            5'd10:   r = 17'd6554;
            5'd11:   r = 17'd5958;
            5'd12:   r = 17'd5462;
            5'd13:   r = 17'd5042;
            5'd14:   r = 17'd4682;
            5'd15:   r = 17'd4370;
            5'd16:   r = 17'd4096;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/cwsi_ctrl.sv]
// ----------------------------------------------------------------------------
// cwsi_ctrl
// Sequencer: takes one sample, steps the window and filler arithmetic and
// hands each result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cwsi_ctrl
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   sample_valid,
    output logic                  sample_ready,
    input  cwsi_pkg::status_t     status,
    output cwsi_pkg::cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN_MUL,
        ST_WIN_RES,
        ST_FILL_STEP,
        ST_FILL_OUT,
        ST_REAL_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        sample_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_WIN_MUL;
                end
            end
            ST_WIN_MUL:
            begin
                cmd.win_mul = 1'b1;
                state_next  = ST_WIN_RES;
            end
            ST_WIN_RES:
            begin
                cmd.win_res = 1'b1;
                state_next  = status.fill_en ? ST_FILL_STEP : ST_REAL_OUT;
            end
            ST_FILL_STEP:
            begin
                cmd.fill_step = 1'b1;
                state_next    = ST_FILL_OUT;
            end
            ST_FILL_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_fill = 1'b1;
                    state_next    = status.last_fill ? ST_REAL_OUT : ST_FILL_STEP;
                end
            end
            ST_REAL_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_real = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/cwsi_datapath.sv]
// ----------------------------------------------------------------------------
// cwsi_datapath
// Configuration registers, pixel and slice counters, previous slice store,
// window and filler arithmetic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cwsi_datapath
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_valid,
    input  wire                                 cfg_index,
    input  wire  [cwsi_pkg::CFG_W-1:0]          cfg_data,
    input  cwsi_pkg::sample_t                   sample,
    input  cwsi_pkg::cmd_t                      cmd,
    output cwsi_pkg::status_t                   status,
    output logic                                voxel_valid,
    input  wire                                 voxel_ready,
    output cwsi_pkg::voxel_t                    voxel
);

    // Configuration
    logic [cwsi_pkg::THICK_W-1:0] thick_reg;
    logic [cwsi_pkg::NPIX_W-1:0]  npix_reg;
    logic [cwsi_pkg::THICK_W-1:0] t_eff;
    logic [cwsi_pkg::NPIX_W-1:0]  n_eff;

    // Counters
    logic [cwsi_pkg::PIX_W-1:0] pix_cnt_reg;
    logic [cwsi_pkg::SLC_W-1:0] slc_cnt_reg;
    logic [cwsi_pkg::PIX_W-1:0] p_sel;
    logic [cwsi_pkg::SLC_W-1:0] s_sel;
    logic [cwsi_pkg::NPIX_W-1:0] p_inc;

    // Item registers
    logic [cwsi_pkg::PIX_W-1:0]    p_reg;
    logic [cwsi_pkg::SLC_W-1:0]    s_reg;
    logic [18:0]                   y_reg;
    logic                          lo_reg;
    logic                          hi_reg;
    logic [38:0]                   wprod_reg;
    logic [cwsi_pkg::OSLICE_W-1:0] base_reg;
    logic [cwsi_pkg::VOX_W-1:0]    cur_reg;
    logic [cwsi_pkg::ACC_W-1:0]    acc_reg;
    logic [28:0]                   fprod_reg;
    logic [cwsi_pkg::LCNT_W-1:0]   l_reg;

    // Store
    logic [cwsi_pkg::VOX_W-1:0] store_mem [cwsi_pkg::MAX_SLICE_PIXELS];
    logic [cwsi_pkg::VOX_W-1:0] store_q;

    // Window front end
    logic [cwsi_pkg::HU_W:0] v_plus;
    logic [10:0]             x_win;
    logic [18:0]             y_win;
    logic                    lo_win;
    logic                    hi_win;
    logic [cwsi_pkg::VOX_W-1:0] cur_next;

    // Filler arithmetic
    logic [8:0]                 diff;
    logic [cwsi_pkg::ACC_W:0]   acc_sum;
    logic [12:0]                acc_init;
    logic [14:0]                base_full;
    logic [cwsi_pkg::OSLICE_W-1:0] fill_slice;

    // Output register
    logic            out_valid_reg;
    cwsi_pkg::voxel_t out_reg;

    // Effective register values
    always_comb
    begin
        if (thick_reg == '0)
            t_eff = 5'd1;
        else if (thick_reg > cwsi_pkg::THICK_MAX)
            t_eff = cwsi_pkg::THICK_MAX;
        else
            t_eff = thick_reg;

        if (npix_reg == '0)
            n_eff = 19'd1;
        else if (npix_reg > cwsi_pkg::NPIX_MAX)
            n_eff = cwsi_pkg::NPIX_MAX;
        else
            n_eff = npix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thick_reg <= 5'd1;
            npix_reg  <= cwsi_pkg::NPIX_MAX;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cwsi_pkg::REG_SLICE_THICKNESS: thick_reg <= cfg_data[cwsi_pkg::THICK_W-1:0];
                cwsi_pkg::REG_SLICE_PIXELS:    npix_reg  <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Counters restart on the first word of a volume
    assign p_sel = sample.first_of_volume ? '0 : pix_cnt_reg;
    assign s_sel = sample.first_of_volume ? '0 : slc_cnt_reg;
    assign p_inc = {1'b0, p_sel} + 19'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_cnt_reg <= '0;
            slc_cnt_reg <= '0;
        end
        else if (cmd.capture)
        begin
            if (p_inc >= n_eff)
            begin
                pix_cnt_reg <= '0;
                slc_cnt_reg <= s_sel + 10'd1;
            end
            else
            begin
                pix_cnt_reg <= p_inc[cwsi_pkg::PIX_W-1:0];
                slc_cnt_reg <= s_sel;
            end
        end
    end

    // Window numerator and clamp flags
    assign v_plus = {sample.hu_sample[cwsi_pkg::HU_W-1], sample.hu_sample} + cwsi_pkg::WIN_OFFSET;
    assign x_win  = v_plus[10:0];
    assign y_win  = {x_win, 8'd0} - {8'd0, x_win};
    assign lo_win = $signed(sample.hu_sample) < cwsi_pkg::WIN_LOW;
    assign hi_win = $signed(sample.hu_sample) > cwsi_pkg::WIN_HIGH;

    always_comb
    begin
        if (lo_reg)
            cur_next = '0;
        else if (hi_reg)
            cur_next = cwsi_pkg::BYTE_MAX;
        else
            cur_next = wprod_reg[cwsi_pkg::WIN_SHIFT+7:cwsi_pkg::WIN_SHIFT];
    end

    // Filler numerator steps by (cur - prev) from prev * T
    assign diff      = {1'b0, cur_reg} - {1'b0, store_q};
    assign acc_sum   = {1'b0, acc_reg} + {{4{diff[8]}}, diff};
    assign acc_init  = store_q * t_eff;
    assign base_full = s_reg * t_eff;
    assign fill_slice = base_reg + {10'd0, l_reg};

    // Item pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            p_reg  <= p_sel;
            s_reg  <= s_sel;
            y_reg  <= y_win;
            lo_reg <= lo_win;
            hi_reg <= hi_win;
        end
        if (cmd.win_mul)
        begin
            wprod_reg <= y_reg * cwsi_pkg::WIN_RECIP;
            base_reg  <= base_full[cwsi_pkg::OSLICE_W-1:0];
        end
        if (cmd.win_res)
        begin
            cur_reg <= cur_next;
            acc_reg <= acc_init[cwsi_pkg::ACC_W-1:0];
            l_reg   <= 4'd1;
        end
        if (cmd.fill_step)
        begin
            acc_reg   <= acc_sum[cwsi_pkg::ACC_W-1:0];
            fprod_reg <= acc_sum[cwsi_pkg::ACC_W-1:0] * cwsi_pkg::fill_recip(t_eff);
        end
        if (cmd.load_fill)
        begin
            l_reg <= l_reg + 4'd1;
        end
    end

    // Previous slice store: read on capture, written with the real voxel
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            store_q <= store_mem[p_sel];
        if (cmd.load_real)
            store_mem[p_reg] <= cur_reg;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_fill || cmd.load_real)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (voxel_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_fill)
        begin
            out_reg.voxel_value <= fprod_reg[cwsi_pkg::FILL_SHIFT+7:cwsi_pkg::FILL_SHIFT];
            out_reg.out_slice   <= fill_slice;
            out_reg.out_pixel   <= p_reg;
            out_reg.last_of_run <= 1'b0;
        end
        else if (cmd.load_real)
        begin
            out_reg.voxel_value <= cur_reg;
            out_reg.out_slice   <= base_reg;
            out_reg.out_pixel   <= p_reg;
            out_reg.last_of_run <= 1'b1;
        end
    end

    assign voxel_valid = out_valid_reg;
    assign voxel       = out_reg;

    // Status
    assign status.fill_en   = (s_reg != '0) && (t_eff > 5'd1);
    assign status.last_fill = ({1'b0, l_reg} + 5'd1) == t_eff;
    assign status.out_free  = !out_valid_reg || voxel_ready;

endmodule

`default_nettype wire

[rtl/core/ct_window_slice_interpolator.sv]
// ----------------------------------------------------------------------------
// ct_window_slice_interpolator
// Windows CT samples to bytes and emits linearly interpolated filler voxels
// between each slice and the previous one.
// ----------------------------------------------------------------------------
//  channel | ports                                  | word
//  --------+----------------------------------------+------------------------
//  sample  | sample_valid, sample_ready, sample     | hu_sample, first flag
//  voxel   | voxel_valid, voxel_ready, voxel        | value, slice, pixel, last
//  cfg     | cfg_valid, cfg_ready, cfg_index, data  | thickness, slice size
//
//  The sequencer captures a sample, multiplies and resolves the window, then
//  on slices after the first steps and loads T-1 fillers one after another
//  before loading the real voxel; a new sample is taken only after that.
//  Reset clears counters, configuration (T = 1, 262144 pixels) and the
//  output register; the slice store holds nothing valid until written.
//  A stalled voxel word holds the sequencer in its output state.
// ----------------------------------------------------------------------------
`default_nettype none

module ct_window_slice_interpolator
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          sample_valid,
    output logic                         sample_ready,
    input  cwsi_pkg::sample_t            sample,
    output logic                         voxel_valid,
    input  wire                          voxel_ready,
    output cwsi_pkg::voxel_t             voxel,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire                          cfg_index,
    input  wire  [cwsi_pkg::CFG_W-1:0]   cfg_data
);

    cwsi_pkg::cmd_t    cmd;
    cwsi_pkg::status_t status;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    cwsi_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    cwsi_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (sample),
        .cmd         (cmd),
        .status      (status),
        .voxel_valid (voxel_valid),
        .voxel_ready (voxel_ready),
        .voxel       (voxel)
    );

endmodule

`default_nettype wire
